### rtl/core/sorted_column_list_macros.svh
// assertion macros for the sorted column list checker
`ifndef SORTED_COLUMN_LIST_MACROS_SVH
`define SORTED_COLUMN_LIST_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scl check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scl check failed");

`endif

### rtl/core/scl_pkg.sv
// shared types and constants for the sorted column list
`timescale 1ns / 1ps
package scl_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY + 1);
  localparam int CNT_W    = SLOT_W;
  localparam int COL_W    = 31;
  localparam int NCOL_W   = COL_W + 1;
  localparam int LVL_W    = 16;
  localparam int VAL_W    = 64;
  localparam int ROW_W    = 31;

  localparam logic [NCOL_W-1:0] COL_MAXV = {1'b0, {COL_W{1'b1}}};
  localparam logic [NCOL_W-1:0] COL_DEAD = {NCOL_W{1'b1}};
  // successor column of a record at the end of the list
  localparam logic [NCOL_W-1:0] COL_END  = {1'b1, {COL_W{1'b0}}};

  typedef enum logic [2:0] {
    CMD_CLEAR        = 3'd0,
    CMD_INSERT       = 3'd1,
    CMD_INSERT_UPD   = 3'd2,
    CMD_DELETE       = 3'd3,
    CMD_REWIND       = 3'd4,
    CMD_GET_SMALLEST = 3'd5,
    CMD_GET_LOWER    = 3'd6,
    CMD_READ_COUNT   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_APPLY, S_DEL2, S_READ, S_DONE
  } state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              look;
    logic              del_mode;
    logic [COL_W-1:0]  key;
    logic [LVL_W-1:0]  level;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  alloc_cnt;
    logic              rd_pred;
    logic              rd_addr_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              new_en;
    logic [SLOT_W-1:0] new_addr;
    logic [SLOT_W-1:0] new_link;
    logic [NCOL_W-1:0] new_nxt;
    logic              pred_en;
    logic [SLOT_W-1:0] pred_link;
    logic [NCOL_W-1:0] pred_nxt;
    logic              upd_en;
    logic              kill_en;
    logic [SLOT_W-1:0] kill_addr;
  } cell_cmd_t;

  // record read back from a selected cell, zero when not selected
  typedef struct packed {
    logic [NCOL_W-1:0] col;
    logic [NCOL_W-1:0] nxt;
    logic [SLOT_W-1:0] link;
    logic [LVL_W-1:0]  level;
    logic [VAL_W-1:0]  value;
  } cell_rd_t;

  typedef struct packed {
    logic pred;
    logic hit;
  } cell_flag_t;

endpackage

### rtl/core/scl_cell.sv
// one record slot of the list, with its link and successor column
`timescale 1ns / 1ps
module scl_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [scl_pkg::SLOT_W-1:0]  idx_i,
  input  scl_pkg::cell_cmd_t          cmd_i,
  output scl_pkg::cell_rd_t           rd_o,
  output scl_pkg::cell_flag_t         flag_o
);
  import scl_pkg::*;

  logic [NCOL_W-1:0] col_q;
  logic [NCOL_W-1:0] nxt_q;
  logic [SLOT_W-1:0] link_q;
  logic [LVL_W-1:0]  level_q;
  logic [VAL_W-1:0]  value_q;
  logic              pred_q;
  logic              hit_q;
  logic              alloc;
  logic              live;
  logic [NCOL_W-1:0] key;
  logic              sel;

  assign key   = {1'b0, cmd_i.key};
  assign alloc = (idx_i <= cmd_i.alloc_cnt);
  assign live  = alloc && !col_q[NCOL_W-1];

  // match flags, taken in the look phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (cmd_i.look) begin
      pred_q <= live && (col_q < key) &&
                (cmd_i.del_mode ? (nxt_q == key) : (nxt_q >= key));
      // last of the equal run in list order is the earliest inserted
      hit_q  <= alloc && (col_q == key) && (nxt_q != key);
    end
  end

  // record contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.new_en && (idx_i == cmd_i.new_addr)) begin
      col_q   <= key;
      level_q <= cmd_i.level;
      value_q <= cmd_i.value;
      link_q  <= cmd_i.new_link;
      nxt_q   <= cmd_i.new_nxt;
    end else begin
      if (cmd_i.pred_en && pred_q) begin
        link_q <= cmd_i.pred_link;
        nxt_q  <= cmd_i.pred_nxt;
      end
      if (cmd_i.upd_en && hit_q && (cmd_i.level < level_q)) begin
        level_q <= cmd_i.level;
      end
      if (cmd_i.kill_en && (idx_i == cmd_i.kill_addr)) begin
        col_q <= COL_DEAD;
      end
    end
  end

  // gated read-out onto the shared bus
  assign sel = (cmd_i.rd_pred && pred_q) ||
               (cmd_i.rd_addr_en && (idx_i == cmd_i.rd_addr));

  always_comb begin
    rd_o = '0;
    if (sel) begin
      rd_o.col   = col_q;
      rd_o.nxt   = nxt_q;
      rd_o.link  = link_q;
      rd_o.level = level_q;
      rd_o.value = value_q;
    end
  end

  assign flag_o.pred = pred_q;
  assign flag_o.hit  = hit_q;

endmodule

### rtl/core/sorted_column_list.sv
// top level: sequencer over a row of record cells
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o   | cmd_i col_i level_i value_i row_i
// out     | output    | out_valid_o/out_ready_i | status_o found_o out_col_o out_level_o
//         |           |                         | out_value_o live_count_o
// cfg     | input     | cfg_we_i                | cfg_data_i
// clear, rewind and read_count go from idle straight to the done step; insert and
// insert_or_update pass look and apply; delete and both gets add a second read over
// the cell row after apply; a delete that finds no record with its column skips it.
// the sequencer holds one item at a time; in_ready_o is high only when it is free.
// a result waits in the output register; the sequencer stalls in its last step
// until that register is free. reset empties the list and sets the row to all ones.
`timescale 1ns / 1ps
module sorted_column_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  cmd_i,
  input  logic [scl_pkg::COL_W-1:0]   col_i,
  input  logic [scl_pkg::LVL_W-1:0]   level_i,
  input  logic [scl_pkg::VAL_W-1:0]   value_i,
  input  logic [scl_pkg::ROW_W-1:0]   row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        found_o,
  output logic [scl_pkg::COL_W-1:0]   out_col_o,
  output logic [scl_pkg::LVL_W-1:0]   out_level_o,
  output logic [scl_pkg::VAL_W-1:0]   out_value_o,
  output logic [scl_pkg::CNT_W-1:0]   live_count_o,
  input  logic                        cfg_we_i,
  input  logic [scl_pkg::ROW_W-1:0]   cfg_data_i
);
  import scl_pkg::*;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [LVL_W-1:0]  level_q, level_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic [SLOT_W-1:0] head_link_q, head_link_d;
  logic [NCOL_W-1:0] head_nxt_q, head_nxt_d;
  logic              head_pred_q, head_pred_d;
  logic [CNT_W-1:0]  alloc_q, alloc_d;
  logic [CNT_W-1:0]  live_q, live_d;
  logic [SLOT_W-1:0] scan_q, scan_d;
  logic [SLOT_W-1:0] lower_q, lower_d;
  logic [NCOL_W-1:0] cur_row_q, cur_row_d;
  logic [ROW_W-1:0]  base_q;
  logic [SLOT_W-1:0] tmp_q, tmp_d;
  status_e           res_status_q, res_status_d;
  logic              res_found_q, res_found_d;
  logic [COL_W-1:0]  res_col_q, res_col_d;
  logic [LVL_W-1:0]  res_level_q, res_level_d;
  logic [VAL_W-1:0]  res_value_q, res_value_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic              out_found_q, out_found_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [LVL_W-1:0]  out_level_q, out_level_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  logic [CNT_W-1:0]  out_live_q, out_live_d;

  cell_cmd_t         cell_cmd;
  cell_rd_t          cell_rd   [CAPACITY];
  cell_flag_t        cell_flag [CAPACITY];
  cell_rd_t          rd_all;
  logic              any_pred;
  logic              any_hit;
  logic [SLOT_W-1:0] pl;
  logic [NCOL_W-1:0] pn;
  logic [SLOT_W-1:0] cursor;
  logic [SLOT_W-1:0] new_slot;
  cell_rd_t          rec;
  logic signed [NCOL_W+1:0] bound_s;
  logic signed [NCOL_W+1:0] colx_s;
  logic              take;

  // cell row
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    scl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(k + 1)),
      .cmd_i  (cell_cmd),
      .rd_o   (cell_rd[k]),
      .flag_o (cell_flag[k])
    );
  end

  // or-reduce the gated read bus and the flags
  always_comb begin
    rd_all   = '0;
    any_pred = 1'b0;
    any_hit  = 1'b0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_all   = cell_rd_t'(rd_all | cell_rd[k]);
      any_pred = any_pred | cell_flag[k].pred;
      any_hit  = any_hit | cell_flag[k].hit;
    end
  end

  assign pl       = any_pred ? rd_all.link : head_link_q;
  assign pn       = any_pred ? rd_all.nxt : head_nxt_q;
  assign cursor   = (cmd_q == CMD_GET_LOWER) ? lower_q : scan_q;
  assign new_slot = alloc_q + CNT_W'(1);

  // record under the cursor, the head reads as the sentinel
  always_comb begin
    rec = rd_all;
    if (tmp_q == '0) begin
      rec       = '0;
      rec.col   = COL_MAXV;
    end
  end

  assign bound_s = $signed({{2{cur_row_q[NCOL_W-1]}}, cur_row_q}) +
                   $signed({3'b000, base_q});
  assign colx_s  = $signed({{2{rec.col[NCOL_W-1]}}, rec.col});
  assign take    = (cmd_q == CMD_GET_LOWER) ? (colx_s < bound_s)
                                            : (rec.col[NCOL_W-1] ||
                                               (rec.col != COL_MAXV));

  // sequencer
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    col_d        = col_q;
    level_d      = level_q;
    value_d      = value_q;
    head_link_d  = head_link_q;
    head_nxt_d   = head_nxt_q;
    head_pred_d  = head_pred_q;
    alloc_d      = alloc_q;
    live_d       = live_q;
    scan_d       = scan_q;
    lower_d      = lower_q;
    cur_row_d    = cur_row_q;
    tmp_d        = tmp_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_col_d    = res_col_q;
    res_level_d  = res_level_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_col_d    = out_col_q;
    out_level_d  = out_level_q;
    out_value_d  = out_value_q;
    out_live_d   = out_live_q;

    cell_cmd           = '0;
    cell_cmd.key       = col_q;
    cell_cmd.level     = level_q;
    cell_cmd.value     = value_q;
    cell_cmd.alloc_cnt = alloc_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = cmd_e'(cmd_i);
          col_d        = col_i;
          level_d      = level_i;
          value_d      = value_i;
          res_status_d = ST_OK;
          res_found_d  = 1'b0;
          res_col_d    = '0;
          res_level_d  = '0;
          res_value_d  = '0;
          state_d      = S_LOOK;
          unique case (cmd_e'(cmd_i))
            CMD_CLEAR: begin
              cur_row_d   = {1'b0, row_i};
              alloc_d     = '0;
              live_d      = '0;
              scan_d      = '0;
              lower_d     = '0;
              head_link_d = '0;
              head_nxt_d  = COL_END;
              state_d     = S_DONE;
            end
            CMD_REWIND: begin
              scan_d  = '0;
              lower_d = '0;
              state_d = S_DONE;
            end
            CMD_READ_COUNT: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_LOOK;
            end
          endcase
        end
      end
      S_LOOK: begin
        cell_cmd.look     = 1'b1;
        cell_cmd.del_mode = (cmd_q == CMD_DELETE);
        head_pred_d = (cmd_q == CMD_DELETE) ? (head_nxt_q == {1'b0, col_q})
                                            : (head_nxt_q >= {1'b0, col_q});
        state_d     = S_APPLY;
      end
      S_APPLY: begin
        state_d = S_DONE;
        case (cmd_q) inside
          CMD_INSERT, CMD_INSERT_UPD: begin
            cell_cmd.rd_pred = 1'b1;
            if ((cmd_q == CMD_INSERT_UPD) && any_hit) begin
              cell_cmd.upd_en = 1'b1;
              res_found_d     = 1'b1;
            end else if (alloc_q == CNT_W'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              cell_cmd.new_en   = 1'b1;
              cell_cmd.new_addr = new_slot;
              cell_cmd.new_link = pl;
              cell_cmd.new_nxt  = pn;
              if (any_pred) begin
                cell_cmd.pred_en   = 1'b1;
                cell_cmd.pred_link = new_slot;
                cell_cmd.pred_nxt  = {1'b0, col_q};
              end else begin
                head_link_d = new_slot;
                head_nxt_d  = {1'b0, col_q};
              end
              alloc_d = new_slot;
              live_d  = live_q + CNT_W'(1);
            end
          end
          CMD_DELETE: begin
            cell_cmd.rd_pred = 1'b1;
            if (!any_pred && !head_pred_q) begin
              res_status_d = ST_MISSING;
            end else begin
              tmp_d   = pl;
              state_d = S_DEL2;
            end
          end
          CMD_GET_SMALLEST, CMD_GET_LOWER: begin
            cell_cmd.rd_addr_en = 1'b1;
            cell_cmd.rd_addr    = cursor;
            tmp_d   = (cursor == '0) ? head_link_q : rd_all.link;
            state_d = S_READ;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DEL2: begin
        // unlink the target: its predecessor takes its link
        cell_cmd.rd_addr_en = 1'b1;
        cell_cmd.rd_addr    = tmp_q;
        cell_cmd.kill_en    = 1'b1;
        cell_cmd.kill_addr  = tmp_q;
        if (any_pred) begin
          cell_cmd.pred_en   = 1'b1;
          cell_cmd.pred_link = rd_all.link;
          cell_cmd.pred_nxt  = rd_all.nxt;
        end else begin
          head_link_d = rd_all.link;
          head_nxt_d  = rd_all.nxt;
        end
        if (live_q != '0) begin
          live_d = live_q - CNT_W'(1);
        end
        state_d = S_DONE;
      end
      S_READ: begin
        cell_cmd.rd_addr_en = 1'b1;
        cell_cmd.rd_addr    = tmp_q;
        if (take) begin
          if (cmd_q == CMD_GET_LOWER) begin
            lower_d = tmp_q;
          end else begin
            scan_d = tmp_q;
          end
          res_found_d = 1'b1;
          res_col_d   = rec.col[COL_W-1:0];
          res_level_d = rec.level;
          res_value_d = rec.value;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_col_d    = res_col_q;
          out_level_d  = res_level_q;
          out_value_d  = res_value_q;
          out_live_d   = live_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_link_q <= '0;
      head_nxt_q  <= COL_END;
      head_pred_q <= 1'b0;
      alloc_q     <= '0;
      live_q      <= '0;
      scan_q      <= '0;
      lower_q     <= '0;
      cur_row_q   <= '1;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_link_q <= head_link_d;
      head_nxt_q  <= head_nxt_d;
      head_pred_q <= head_pred_d;
      alloc_q     <= alloc_d;
      live_q      <= live_d;
      scan_q      <= scan_d;
      lower_q     <= lower_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    col_q        <= col_d;
    level_q      <= level_d;
    value_q      <= value_d;
    tmp_q        <= tmp_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_col_q    <= res_col_d;
    res_level_q  <= res_level_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_col_q    <= out_col_d;
    out_level_q  <= out_level_d;
    out_value_q  <= out_value_d;
    out_live_q   <= out_live_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_o      = out_found_q;
  assign out_col_o    = out_col_q;
  assign out_level_o  = out_level_q;
  assign out_value_o  = out_value_q;
  assign live_count_o = out_live_q;

endmodule

### rtl/core/scl_checker.sv
// port-level checks for the sorted column list, bound to the top level
`timescale 1ns / 1ps
`include "sorted_column_list_macros.svh"
module scl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic                        found_o,
  input logic [scl_pkg::COL_W-1:0]   out_col_o,
  input logic [scl_pkg::LVL_W-1:0]   out_level_o,
  input logic [scl_pkg::VAL_W-1:0]   out_value_o,
  input logic [scl_pkg::CNT_W-1:0]   live_count_o
);
  import scl_pkg::*;

  // a stalled result holds
  `SCL_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_col_o) && $stable(live_count_o))

  // one item in flight: no new item right after an accepted one
  `SCL_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o)

  // a returned or updated record never carries an error
  `SCL_ASSERT_IMP(a_found_ok, out_valid_o && found_o, status_o == ST_OK)

  // nothing returned means an all-zero record
  `SCL_ASSERT_IMP(a_empty_rec, out_valid_o && !found_o, (out_col_o == '0) && (out_level_o == '0) && (out_value_o == '0))

endmodule

bind sorted_column_list scl_checker u_scl_checker (.*);
